// File: hw/rtl/vdi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vdi_pkg: shared constants and types of the vertex de-duplication indexer
// Sizes of the vertex table, attribute format and the stage record that
// travels along the cell chain.
// ---------------------------------------------------------------------------
package vdi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ATTR_COUNT  = 8;
  localparam int ATTR_BITS   = 32;

  localparam int FIELD_BITS  = 32;
  localparam int TOL_BITS    = 31;
  localparam int OUT_IDX_W   = 10;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DIFF_W      = ATTR_BITS + 1;
  localparam int CMP_W       = (DIFF_W > TOL_BITS) ? DIFF_W : TOL_BITS;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(655);

  typedef logic [ATTR_BITS-1:0] attr_t;
  typedef attr_t [ATTR_COUNT-1:0] vertex_t;

  // One vertex on its way along the chain.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              reused;
    logic [IDX_W-1:0]  idx;
    vertex_t           attrs;
  } stage_t;

endpackage
`default_nettype wire

// File: hw/rtl/vdi_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vdi_if: channel interfaces of the vertex de-duplication indexer
// Valid/ready channels for vertices, results and the tolerance register.
// ---------------------------------------------------------------------------
interface vdi_in_if import vdi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] pos_x;
  logic [FIELD_BITS-1:0] pos_y;
  logic [FIELD_BITS-1:0] pos_z;
  logic [FIELD_BITS-1:0] tex_u;
  logic [FIELD_BITS-1:0] tex_v;
  logic [FIELD_BITS-1:0] norm_x;
  logic [FIELD_BITS-1:0] norm_y;
  logic [FIELD_BITS-1:0] norm_z;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface vdi_out_if import vdi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] vertex_index;
  logic                 reused;
  logic                 table_full;
  modport source (output valid, vertex_index, reused, table_full, input ready);
  modport sink   (input valid, vertex_index, reused, table_full, output ready);
endinterface

interface vdi_cfg_if import vdi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TOL_BITS-1:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink   (input valid, tolerance, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vertex_dedup_indexer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vertex_dedup_indexer: tolerant vertex de-duplication for index buffers
// Usage:
//   in_ch carries one vertex per transfer (eight signed Q16.16 attributes).
//   out_ch returns one result per vertex, in order: the index of the first
//   stored vertex whose attributes all lie strictly within the tolerance,
//   flagged reused, or the index of the newly appended entry, or index 0
//   with table_full when no match exists and every entry is taken.
//   cfg_ch writes the tolerance; write it only while no vertex is in flight.
// Throughput:
//   The vertex walks a chain of TABLE_DEPTH cells, one cell per cycle while
//   the chain is not held (see Stall), and is registered in every cell
//   before its result reaches out_ch. One vertex can enter every cycle
//   unless the chain holds; each sees all appends of earlier vertices because
//   those are always ahead of it in the chain.
// Reset:
//   All entries are marked empty and the tolerance returns to about 0.01.
// Stall:
//   When out_ch is stalled with a result waiting, the whole chain holds and
//   in_ch.ready drops until the result is taken.
// ---------------------------------------------------------------------------
module vertex_dedup_indexer import vdi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  vdi_in_if.sink    in_ch,
  vdi_out_if.source out_ch,
  vdi_cfg_if.sink   cfg_ch
);

  logic [TOL_BITS-1:0] tol_r;
  logic                adv;
  stage_t              head;
  stage_t              chain [TABLE_DEPTH+1];
  stage_t              last;
  logic [OUT_IDX_W+IDX_W-1:0] idx_wide;

  // Tolerance register; the port always takes the write.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.tolerance;
    end
  end

  // The chain moves as a whole whenever the result slot is free or drains.
  assign last = chain[TABLE_DEPTH];
  assign adv  = !last.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Entry to the chain: take the low attribute bits of each field.
  always_comb begin
    head          = '0;
    head.valid    = in_ch.valid;
    head.attrs[0] = in_ch.pos_x[ATTR_BITS-1:0];
    head.attrs[1] = in_ch.pos_y[ATTR_BITS-1:0];
    head.attrs[2] = in_ch.pos_z[ATTR_BITS-1:0];
    head.attrs[3] = in_ch.tex_u[ATTR_BITS-1:0];
    head.attrs[4] = in_ch.tex_v[ATTR_BITS-1:0];
    head.attrs[5] = in_ch.norm_x[ATTR_BITS-1:0];
    head.attrs[6] = in_ch.norm_y[ATTR_BITS-1:0];
    head.attrs[7] = in_ch.norm_z[ATTR_BITS-1:0];
  end

  assign chain[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vdi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(i)),
      .tol      (tol_r),
      .stage_i  (chain[i]),
      .stage_o  (chain[i+1])
    );
  end

  // A vertex that leaves the chain unresolved found no match and no room.
  assign idx_wide            = {{OUT_IDX_W{1'b0}}, last.idx};
  assign out_ch.valid        = last.valid;
  assign out_ch.vertex_index = last.done ? idx_wide[OUT_IDX_W-1:0] : '0;
  assign out_ch.reused       = last.done & last.reused;
  assign out_ch.table_full   = !last.done;

endmodule
`default_nettype wire

// File: hw/rtl/vdi_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vdi_cell: one table entry of the indexer chain
// Holds one stored vertex, compares the passing vertex against it and
// claims the entry for the first unmatched vertex that finds it empty.
// ---------------------------------------------------------------------------
module vdi_cell import vdi_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [IDX_W-1:0]    cell_idx,
  input  wire logic [TOL_BITS-1:0] tol,
  input  wire stage_t              stage_i,
  output stage_t                   stage_o
);

  logic    ent_valid_r;
  vertex_t ent_r;
  stage_t  stage_r;
  stage_t  stage_nxt;
  logic    match;
  logic    store;

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic [CMP_W-1:0]         mag;
    match = ent_valid_r;
    for (int k = 0; k < ATTR_COUNT; k++) begin
      d   = $signed({ent_r[k][ATTR_BITS-1], ent_r[k]}) -
            $signed({stage_i.attrs[k][ATTR_BITS-1], stage_i.attrs[k]});
      mag = CMP_W'(d[DIFF_W-1] ? -d : d);
      if (!(mag < CMP_W'(tol))) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    stage_nxt = stage_i;
    store     = 1'b0;
    if (stage_i.valid && !stage_i.done) begin
      if (match) begin
        stage_nxt.done   = 1'b1;
        stage_nxt.reused = 1'b1;
        stage_nxt.idx    = cell_idx;
      end else if (!ent_valid_r) begin
        store            = 1'b1;
        stage_nxt.done   = 1'b1;
        stage_nxt.reused = 1'b0;
        stage_nxt.idx    = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r   <= 1'b0;
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
      if (store) begin
        ent_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && store) begin
      ent_r <= stage_i.attrs;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

// File: verif/vdi_tb_if.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vdi_tb_if: testbench view of the indexer channels
// The block's channel interfaces are reused as they are; this file only
// supplies the record that the checker keeps for each expected result.
// ---------------------------------------------------------------------------
package vdi_tb_pkg;
  import vdi_pkg::*;

  typedef struct {
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 reused;
    logic                 table_full;
  } index_result_t;
endpackage

// File: verif/vdi_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vdi_checker: predicts and checks indexer results
// Watches vertex, tolerance and result transfers, keeps its own table of
// unique vertices and compares every result against the oldest prediction.
// ---------------------------------------------------------------------------
module vdi_checker import vdi_pkg::*, vdi_tb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  vdi_in_if         in_ch,
  vdi_out_if        out_ch,
  vdi_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending_count
);

  logic signed [ATTR_BITS-1:0] uniq_table [TABLE_DEPTH][ATTR_COUNT];
  int unsigned                 uniq_count;
  logic [TOL_BITS-1:0]         match_tol;
  index_result_t               pending_results [$];

  assign pending_count = pending_results.size();

  function automatic index_result_t index_vertex(logic signed [ATTR_BITS-1:0] v [ATTR_COUNT]);
    index_result_t r;
    logic signed [DIFF_W:0] d;
    bit hit;
    for (int e = 0; e < uniq_count; e++) begin
      hit = 1;
      for (int k = 0; k < ATTR_COUNT; k++) begin
        d = (DIFF_W+1)'(uniq_table[e][k]) - (DIFF_W+1)'(v[k]);
        if (d < 0) d = -d;
        if (!(d < $signed({2'b00, match_tol}))) hit = 0;
      end
      if (hit) begin
        r.vertex_index = OUT_IDX_W'(e);
        r.reused = 1;
        r.table_full = 0;
        return r;
      end
    end
    if (uniq_count >= TABLE_DEPTH) begin
      r.vertex_index = '0;
      r.reused = 0;
      r.table_full = 1;
      return r;
    end
    for (int k = 0; k < ATTR_COUNT; k++) uniq_table[uniq_count][k] = v[k];
    r.vertex_index = OUT_IDX_W'(uniq_count);
    r.reused = 0;
    r.table_full = 0;
    uniq_count++;
    return r;
  endfunction

  always @(posedge clk) begin
    logic signed [ATTR_BITS-1:0] v [ATTR_COUNT];
    index_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      uniq_count = 0;
      match_tol = TOL_RESET;
      fail_count <= 0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) match_tol = cfg_ch.tolerance;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errs++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.vertex_index !== exp_r.vertex_index) begin
            $error("vertex_index: expected %0d, actual %0d", exp_r.vertex_index,
                   out_ch.vertex_index);
            errs++;
          end
          if (out_ch.reused !== exp_r.reused) begin
            $error("reused: expected %0b, actual %0b", exp_r.reused, out_ch.reused);
            errs++;
          end
          if (out_ch.table_full !== exp_r.table_full) begin
            $error("table_full: expected %0b, actual %0b", exp_r.table_full,
                   out_ch.table_full);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        v[0] = in_ch.pos_x;  v[1] = in_ch.pos_y;  v[2] = in_ch.pos_z;
        v[3] = in_ch.tex_u;  v[4] = in_ch.tex_v;
        v[5] = in_ch.norm_x; v[6] = in_ch.norm_y; v[7] = in_ch.norm_z;
        pending_results = {pending_results, index_vertex(v)};
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: verif/tb_vertex_dedup_indexer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vertex_dedup_indexer: top of the vertex de-duplication indexer bench
// Drives vertex streams made of a small pool of base vertices, jittered
// around the tolerance, through several tolerance settings, and leaves the
// checking to vdi_checker.
// ---------------------------------------------------------------------------
module tb_vertex_dedup_indexer import vdi_pkg::*; ();

  localparam int DRAIN_CYCLES = TABLE_DEPTH + 50;
  localparam int HOLD_CYCLES  = TABLE_DEPTH + 300;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  bit   hold_req;      // asks the hold-off process for its long stretch
  bit   stall_on;      // receiver hold-off, timed by its own process
  bit   no_idle;       // a stretch where neither side idles

  vdi_in_if  in_ch();
  vdi_out_if out_ch();
  vdi_cfg_if cfg_ch();

  vertex_dedup_indexer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  vdi_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The current tolerance, tracked here so that near misses can be aimed at it.
  logic [TOL_BITS-1:0] cur_tol;
  // Base vertices that later items are made to resemble.
  logic [ATTR_BITS-1:0] base_pool [16][ATTR_COUNT];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Generous limit: every item passing the whole chain, stalls included.
  initial begin
    #(12 * 2000000);
    $display("Verification failed");
    $finish;
  end

  // Long receiver hold-off, long enough for results to reach the chain end
  // and block the input while the sender keeps offering vertices.
  initial begin
    stall_on = 1'b0;
    wait (hold_req);
    stall_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    stall_on = 1'b0;
  end

  // The receiver is ready with a chance of 74 in 100, except during the
  // long hold-off and the idle-free stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_on) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // Sends one vertex, holding it until the block takes it. Valid stays high
  // after the transfer so that the next vertex can follow without a gap.
  task automatic send_vertex(input logic [ATTR_BITS-1:0] a [ATTR_COUNT]);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.pos_x <= a[0]; in_ch.pos_y <= a[1]; in_ch.pos_z <= a[2];
    in_ch.tex_u <= a[3]; in_ch.tex_v <= a[4];
    in_ch.norm_x <= a[5]; in_ch.norm_y <= a[6]; in_ch.norm_z <= a[7];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Waits until every expected result has come and the chain is empty.
  task automatic drain_chain();
    in_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_BITS-1:0] t);
    cfg_ch.valid <= 1;
    cfg_ch.tolerance <= t;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 0;
    cur_tol = t;
  endtask

  // Offsets one attribute by nothing, by a distance just inside, on, or just past the
  // tolerance, or by a random amount.
  function automatic logic [ATTR_BITS-1:0] jitter(input logic [ATTR_BITS-1:0] b);
    logic [ATTR_BITS:0] off;
    case ($urandom_range(5))
      0: off = '0;
      1: off = (cur_tol == '0) ? '0 : (ATTR_BITS+1)'(cur_tol - 1'b1);
      2: off = (ATTR_BITS+1)'(cur_tol);
      3: off = (ATTR_BITS+1)'(cur_tol) + 1'b1;
      4: off = (ATTR_BITS+1)'($urandom_range(cur_tol));
      default: off = (ATTR_BITS+1)'($urandom);
    endcase
    return $urandom_range(1) ? b + off[ATTR_BITS-1:0] : b - off[ATTR_BITS-1:0];
  endfunction

  function automatic logic [ATTR_BITS-1:0] rand_attr();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random phase: mostly near copies of pooled vertices, some fresh ones.
  task automatic random_phase(input int count);
    logic [ATTR_BITS-1:0] a [ATTR_COUNT];
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(15);
      if ($urandom_range(99) < 20) begin
        for (int k = 0; k < ATTR_COUNT; k++) base_pool[p][k] = rand_attr();
        a = base_pool[p];
      end else begin
        for (int k = 0; k < ATTR_COUNT; k++)
          a[k] = ($urandom_range(3) == 0) ? base_pool[p][k] : jitter(base_pool[p][k]);
      end
      send_vertex(a);
    end
  endtask

  initial begin
    logic [ATTR_BITS-1:0] a [ATTR_COUNT];
    rst_n = 0;
    hold_req = 0;
    no_idle = 0;
    cur_tol = TOL_RESET;
    in_ch.valid = 0;
    in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
    in_ch.tex_u = 0; in_ch.tex_v = 0;
    in_ch.norm_x = 0; in_ch.norm_y = 0; in_ch.norm_z = 0;
    cfg_ch.valid = 0;
    cfg_ch.tolerance = 0;
    for (int p = 0; p < 16; p++)
      for (int k = 0; k < ATTR_COUNT; k++) base_pool[p][k] = $urandom;
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: extremes under the reset tolerance, then exact and near repeats.
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'h8000_0000;
    send_vertex(a);
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'h7FFF_FFFF;
    send_vertex(a);
    send_vertex(a);                       // exact repeat is reused
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'h7FFF_FFFF - 654;
    send_vertex(a);                       // just inside the tolerance
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'h7FFF_FFFF - 655;
    send_vertex(a);                       // exactly on the tolerance: new entry
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 0;
    send_vertex(a);
    a[3] = 32'hFFFF_FFFF;
    send_vertex(a);                       // a near repeat of the all-zero entry is reused
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'hAAAA_5555;
    send_vertex(a);
    for (int k = 0; k < ATTR_COUNT; k++) a[k] = 32'h5555_AAAA;
    send_vertex(a);

    // Long receiver hold-off: the first batch reaches the chain end while
    // the second batch is still being offered, so the input stalls.
    drain_chain();
    hold_req = 1;
    random_phase(40);
    in_ch.valid <= 0;
    repeat (TABLE_DEPTH - 60) @(negedge clk);
    random_phase(40);
    drain_chain();                        // sender pauses until all results came

    // Maximum tolerance: a vertex reuses the lowest entry within range of it.
    write_tolerance({TOL_BITS{1'b1}});
    random_phase(30);
    drain_chain();

    // Moderate tolerance with an idle-free stretch.
    write_tolerance(TOL_BITS'(32'h0001_0000));
    no_idle = 1;
    random_phase(80);
    no_idle = 0;
    random_phase(80);
    drain_chain();

    // Zero tolerance: every vertex is appended as a new entry while room remains.
    write_tolerance('0);
    random_phase(130);
    drain_chain();

    write_tolerance(TOL_RESET);
    random_phase(80);
    drain_chain();

    write_tolerance(TOL_BITS'($urandom));
    random_phase(60);

    drain_chain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
